FILE: hw/rtl/srs_seq_pkg.sv
// Shared types and constants of the selective-repeat sender sequencer.
package srs_seq_pkg;

    localparam int FRAME_W   = 6;
    localparam int BASE_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIND_WAIT,
        S_SLIDE,
        S_SLIDE_WAIT,
        S_POST,
        S_OPEN,
        S_CLEAR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic capture;
        logic capture_zero;
        logic ptr_inc;
        logic rd_ptr;
        logic rd_base;
        logic base_inc;
        logic retx_set;
        logic retx_clr;
        logic scan_ptr;
        logic scan_base;
        logic finish;
        logic open;
        logic clr_write;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic ptr_end;
        logic base_end;
        logic base_done;
        logic clr_done;
        logic rd_bit;
        logic retx;
        logic finished;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/srs_seq_dp.sv
// Datapath: configuration, acknowledge bitmap memory, window pointers and result register.
module srs_seq_dp #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [srs_seq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srs_seq_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                   frame_delivered,
    input  logic                                   ack_delivered,
    input  srs_seq_pkg::cmd_t                      cmd,
    output srs_seq_pkg::sts_t                      sts,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [srs_seq_pkg::FRAME_W-1:0]        frame_index,
    output logic                                   was_retransmission,
    output logic                                   ack_recorded,
    output logic [srs_seq_pkg::BASE_W-1:0]         window_base,
    output logic [srs_seq_pkg::FRAME_W-1:0]        next_frame,
    output logic                                   next_is_retransmission,
    output logic                                   all_done
);

    localparam int FW = srs_seq_pkg::FRAME_W;
    localparam int BW = srs_seq_pkg::BASE_W;
    localparam int GW = srs_seq_pkg::CFG_W;
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int SW = (CW > GW) ? CW : GW;

    logic [GW-1:0] fc_reg;
    logic [GW-1:0] ws_reg;
    logic [CW-1:0] base_reg;
    logic [CW-1:0] round_end_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] clr_ptr_reg;
    logic [AW-1:0] scan_reg;
    logic          retx_reg;
    logic          finished_reg;
    logic [AW-1:0] fi_reg;
    logic          wr_reg;
    logic          ar_reg;
    logic          rd_bit_reg;
    logic          out_valid_reg;
    logic [FW-1:0] frame_index_reg;
    logic          was_retx_reg;
    logic          ack_rec_reg;
    logic [BW-1:0] window_base_reg;
    logic [FW-1:0] next_frame_reg;
    logic          next_retx_reg;
    logic          all_done_reg;

    logic          mem [MAX_FRAMES];

    logic [CW-1:0] cnt;
    logic [CW-1:0] win;
    logic [CW:0]   win_sum;
    logic [CW-1:0] win_end;
    logic          ack_now;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_wd;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        if (fc_reg == '0)
        begin
            cnt = CW'(1);
        end
        else if (SW'(fc_reg) > SW'(MAX_FRAMES))
        begin
            cnt = CW'(MAX_FRAMES);
        end
        else
        begin
            cnt = CW'(fc_reg);
        end
    end

    always_comb
    begin
        if (ws_reg == '0)
        begin
            win = CW'(1);
        end
        else if (SW'(ws_reg) > SW'(cnt))
        begin
            win = cnt;
        end
        else
        begin
            win = CW'(ws_reg);
        end
    end

    assign win_sum = {1'b0, base_reg} + {1'b0, win};
    assign win_end = (win_sum > {1'b0, cnt}) ? cnt : win_sum[CW-1:0];

    assign ack_now = frame_delivered & ack_delivered;
    assign mem_we  = cmd.clr_write | (cmd.capture & ack_now);
    assign mem_wa  = cmd.clr_write ? clr_ptr_reg[AW-1:0] : scan_reg;
    assign mem_wd  = cmd.capture;
    assign rd_addr = cmd.rd_base ? base_reg[AW-1:0] : ptr_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_ptr || cmd.rd_base)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= GW'(1);
            ws_reg <= GW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srs_seq_pkg::CFG_FRAME_COUNT: fc_reg <= cfg_data;
                srs_seq_pkg::CFG_WINDOW_SIZE: ws_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            round_end_reg <= '0;
            ptr_reg       <= '0;
            clr_ptr_reg   <= '0;
            scan_reg      <= '0;
            retx_reg      <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            base_reg      <= '0;
            round_end_reg <= '0;
            scan_reg      <= '0;
            retx_reg      <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                ptr_reg <= CW'(scan_reg) + CW'(1);
            end
            if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.base_inc)
            begin
                base_reg <= base_reg + CW'(1);
            end
            if (cmd.scan_ptr)
            begin
                scan_reg <= ptr_reg[AW-1:0];
            end
            if (cmd.scan_base)
            begin
                scan_reg <= base_reg[AW-1:0];
            end
            if (cmd.retx_set)
            begin
                retx_reg <= 1'b1;
            end
            if (cmd.retx_clr)
            begin
                retx_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                finished_reg <= 1'b1;
                scan_reg     <= '0;
            end
            if (cmd.open)
            begin
                round_end_reg <= win_end;
                clr_ptr_reg   <= round_end_reg;
                scan_reg      <= base_reg[AW-1:0];
            end
            if (cmd.clr_write)
            begin
                clr_ptr_reg <= clr_ptr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fi_reg <= scan_reg;
            wr_reg <= retx_reg;
            ar_reg <= ack_now;
        end
        else if (cmd.capture_zero)
        begin
            fi_reg <= '0;
            wr_reg <= 1'b0;
            ar_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            frame_index_reg <= FW'(fi_reg);
            was_retx_reg    <= wr_reg;
            ack_rec_reg     <= ar_reg;
            window_base_reg <= BW'(base_reg);
            next_frame_reg  <= FW'(scan_reg);
            next_retx_reg   <= retx_reg;
            all_done_reg    <= finished_reg;
        end
    end

    assign sts.ptr_end   = (ptr_reg >= round_end_reg);
    assign sts.base_end  = (base_reg >= round_end_reg);
    assign sts.base_done = (base_reg >= cnt);
    assign sts.clr_done  = (clr_ptr_reg >= round_end_reg);
    assign sts.rd_bit    = rd_bit_reg;
    assign sts.retx      = retx_reg;
    assign sts.finished  = finished_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid              = out_valid_reg;
    assign frame_index            = frame_index_reg;
    assign was_retransmission     = was_retx_reg;
    assign ack_recorded           = ack_rec_reg;
    assign window_base            = window_base_reg;
    assign next_frame             = next_frame_reg;
    assign next_is_retransmission = next_retx_reg;
    assign all_done               = all_done_reg;

    a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_wa) < round_end_reg))
        else $error("bitmap write outside the open window");

    a_base_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= round_end_reg)
        else $error("window base beyond round end");

    a_done_base: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (base_reg == cnt))
        else $error("transfer finished with base short of frame count");

endmodule

FILE: hw/rtl/srs_seq_ctrl.sv
// Controller: sequences query handling, window walks, slides and clearing passes.
module srs_seq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               in_valid,
    input  logic               restart,
    output logic               in_stall,
    input  srs_seq_pkg::sts_t  sts,
    output srs_seq_pkg::cmd_t  cmd
);

    srs_seq_pkg::state_t state_reg;
    srs_seq_pkg::state_t state_next;
    logic                owe_reg;
    logic                owe_next;
    logic                accept;

    assign in_stall = (state_reg != srs_seq_pkg::S_IDLE) || cfg_we;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srs_seq_pkg::S_OPEN;
            owe_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            owe_reg   <= owe_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        owe_next   = owe_reg;
        if (cfg_we)
        begin
            state_next = srs_seq_pkg::S_OPEN;
            owe_next   = 1'b0;
        end
        else
        begin
            case (state_reg)
                srs_seq_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        owe_next = 1'b1;
                        if (restart)
                        begin
                            state_next = srs_seq_pkg::S_OPEN;
                        end
                        else if (sts.finished)
                        begin
                            state_next = srs_seq_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = srs_seq_pkg::S_FIND;
                        end
                    end
                end
                srs_seq_pkg::S_FIND:
                begin
                    state_next = sts.ptr_end ? srs_seq_pkg::S_SLIDE
                                             : srs_seq_pkg::S_FIND_WAIT;
                end
                srs_seq_pkg::S_FIND_WAIT:
                begin
                    state_next = sts.rd_bit ? srs_seq_pkg::S_FIND : srs_seq_pkg::S_EMIT;
                end
                srs_seq_pkg::S_SLIDE:
                begin
                    state_next = sts.base_end ? srs_seq_pkg::S_POST
                                              : srs_seq_pkg::S_SLIDE_WAIT;
                end
                srs_seq_pkg::S_SLIDE_WAIT:
                begin
                    state_next = sts.rd_bit ? srs_seq_pkg::S_SLIDE : srs_seq_pkg::S_POST;
                end
                srs_seq_pkg::S_POST:
                begin
                    if ((!sts.retx && !sts.base_end) || sts.base_done)
                    begin
                        state_next = srs_seq_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = srs_seq_pkg::S_OPEN;
                    end
                end
                srs_seq_pkg::S_OPEN:
                begin
                    state_next = srs_seq_pkg::S_CLEAR;
                end
                srs_seq_pkg::S_CLEAR:
                begin
                    if (sts.clr_done)
                    begin
                        state_next = owe_reg ? srs_seq_pkg::S_EMIT : srs_seq_pkg::S_IDLE;
                    end
                end
                srs_seq_pkg::S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_next = srs_seq_pkg::S_IDLE;
                        owe_next   = 1'b0;
                    end
                end
                default:
                begin
                    state_next = srs_seq_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        if (cfg_we)
        begin
            cmd.start = 1'b1;
        end
        else
        begin
            case (state_reg)
                srs_seq_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            cmd.start        = 1'b1;
                            cmd.capture_zero = 1'b1;
                        end
                        else if (sts.finished)
                        begin
                            cmd.capture_zero = 1'b1;
                        end
                        else
                        begin
                            cmd.capture = 1'b1;
                        end
                    end
                end
                srs_seq_pkg::S_FIND:
                begin
                    cmd.rd_ptr = !sts.ptr_end;
                end
                srs_seq_pkg::S_FIND_WAIT:
                begin
                    cmd.ptr_inc  = sts.rd_bit;
                    cmd.scan_ptr = !sts.rd_bit;
                end
                srs_seq_pkg::S_SLIDE:
                begin
                    cmd.rd_base = !sts.base_end;
                end
                srs_seq_pkg::S_SLIDE_WAIT:
                begin
                    cmd.base_inc = sts.rd_bit;
                end
                srs_seq_pkg::S_POST:
                begin
                    if (!sts.retx && !sts.base_end)
                    begin
                        cmd.retx_set  = 1'b1;
                        cmd.scan_base = 1'b1;
                    end
                    else
                    begin
                        cmd.retx_clr = 1'b1;
                        cmd.finish   = sts.base_done;
                    end
                end
                srs_seq_pkg::S_OPEN:
                begin
                    cmd.open = 1'b1;
                end
                srs_seq_pkg::S_CLEAR:
                begin
                    cmd.clr_write = !sts.clr_done;
                end
                srs_seq_pkg::S_EMIT:
                begin
                    cmd.emit = sts.out_free;
                end
                default: ;
            endcase
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an unaccepted result");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_ptr, cmd.rd_base, cmd.clr_write, cmd.capture}))
        else $error("conflicting bitmap memory operations");

endmodule

FILE: hw/rtl/selective_repeat_sender_sequencer.sv
// Selective-repeat sender sequencer top level: controller and datapath.
// A request runs the find walk over the bitmap entries; at a pass end the slide walk follows,
// and it may open a new window, clearing each frame that the window newly opens.
// One request in flight at a time; a stalled result holds the next.
// Reset: clears control state, then clears the first window, min(window, count) frames,
// one per cycle; the same pass follows every restart and configuration write.
module selective_repeat_sender_sequencer #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [srs_seq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srs_seq_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    input  logic                                   frame_delivered,
    input  logic                                   ack_delivered,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [srs_seq_pkg::FRAME_W-1:0]        frame_index,
    output logic                                   was_retransmission,
    output logic                                   ack_recorded,
    output logic [srs_seq_pkg::BASE_W-1:0]         window_base,
    output logic [srs_seq_pkg::FRAME_W-1:0]        next_frame,
    output logic                                   next_is_retransmission,
    output logic                                   all_done
);

    srs_seq_pkg::cmd_t cmd;
    srs_seq_pkg::sts_t sts;

    srs_seq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (in_valid),
        .restart  (restart),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    srs_seq_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .frame_delivered        (frame_delivered),
        .ack_delivered          (ack_delivered),
        .cmd                    (cmd),
        .sts                    (sts),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .frame_index            (frame_index),
        .was_retransmission     (was_retransmission),
        .ack_recorded           (ack_recorded),
        .window_base            (window_base),
        .next_frame             (next_frame),
        .next_is_retransmission (next_is_retransmission),
        .all_done               (all_done)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the selective-repeat sender sequencer.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_FRAMES  = 64;
    localparam int ITEMS       = 800;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 400;
    localparam int FRAME_W     = srs_seq_pkg::FRAME_W;
    localparam int BASE_W      = srs_seq_pkg::BASE_W;
    localparam int CFG_W       = srs_seq_pkg::CFG_W;
    localparam int CFG_IDX_W   = srs_seq_pkg::CFG_IDX_W;

    typedef struct packed {
        logic restart;
        logic frame_ok;
        logic ack_ok;
    } query_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               retx;
        logic               acked;
        logic [BASE_W-1:0]  base;
        logic [FRAME_W-1:0] next;
        logic               next_retx;
        logic               done;
    } outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 restart;
    logic                 frame_delivered;
    logic                 ack_delivered;
    logic                 out_valid;
    logic                 out_stall;
    logic [FRAME_W-1:0]   frame_index;
    logic                 was_retransmission;
    logic                 ack_recorded;
    logic [BASE_W-1:0]    window_base;
    logic [FRAME_W-1:0]   next_frame;
    logic                 next_is_retransmission;
    logic                 all_done;

    selective_repeat_sender_sequencer #(
        .MAX_FRAMES(MAX_FRAMES)
    ) dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .restart                (restart),
        .frame_delivered        (frame_delivered),
        .ack_delivered          (ack_delivered),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .frame_index            (frame_index),
        .was_retransmission     (was_retransmission),
        .ack_recorded           (ack_recorded),
        .window_base            (window_base),
        .next_frame             (next_frame),
        .next_is_retransmission (next_is_retransmission),
        .all_done               (all_done)
    );

    query_t   query_q[$];
    outcome_t outcome_q[$];
    query_t   next_query;
    outcome_t want;

    int queries_sent;
    int queries_taken;
    int mismatches;
    int quiet_cycles;
    int gap_left;
    int stall_left;
    bit req_taken;
    bit idle_on;

    logic [MAX_FRAMES-1:0] acked_bits;
    logic [CFG_W-1:0]      count_reg;
    logic [CFG_W-1:0]      width_reg;
    int unsigned           base_f;
    int unsigned           round_lim;
    int unsigned           scan_at;
    bit                    retx_pass;
    bit                    xfer_done;

    function automatic int unsigned clamp_count(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_FRAMES)
            return MAX_FRAMES;
        return 32'(v);
    endfunction

    function automatic int unsigned round_limit(input int unsigned from);
        int unsigned n;
        int unsigned w;
        n = clamp_count(count_reg);
        w = (width_reg == 0) ? 1 : ((32'(width_reg) > n) ? n : 32'(width_reg));
        return (from + w > n) ? n : from + w;
    endfunction

    function automatic void begin_transfer();
        acked_bits = '0;
        base_f     = 0;
        round_lim  = round_limit(0);
        scan_at    = 0;
        retx_pass  = 0;
        xfer_done  = 0;
    endfunction

    function automatic int unsigned first_open(input int unsigned from, input int unsigned lim);
        for (int unsigned i = from; i < lim && i < MAX_FRAMES; i++)
        begin
            if (!acked_bits[i])
                return i;
        end
        return lim;
    endfunction

    function automatic void slide_window();
        while (base_f < clamp_count(count_reg) && base_f < MAX_FRAMES && acked_bits[base_f])
            base_f++;
    endfunction

    function automatic void step_scan();
        int unsigned nx;
        nx = first_open(scan_at + 1, round_lim);
        if (nx < round_lim)
        begin
            scan_at = nx;
            return;
        end
        if (!retx_pass)
        begin
            slide_window();
            retx_pass = 1;
            nx = first_open(base_f, round_lim);
            if (nx < round_lim)
            begin
                scan_at = nx;
                return;
            end
        end
        slide_window();
        retx_pass = 0;
        if (base_f >= clamp_count(count_reg))
        begin
            xfer_done = 1;
            scan_at   = 0;
            return;
        end
        round_lim = round_limit(base_f);
        scan_at   = base_f;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        if (idx == srs_seq_pkg::CFG_FRAME_COUNT)
            count_reg = val;
        else if (idx == srs_seq_pkg::CFG_WINDOW_SIZE)
            width_reg = val;
        else
            return;
        begin_transfer();
    endfunction

    function automatic outcome_t predict_outcome(input query_t q);
        outcome_t o;
        o = '0;
        if (q.restart)
        begin
            begin_transfer();
        end
        else if (!xfer_done)
        begin
            o.frame = scan_at[FRAME_W-1:0];
            o.retx  = retx_pass;
            if (q.frame_ok && q.ack_ok)
                acked_bits[scan_at] = 1'b1;
            o.acked = acked_bits[scan_at];
            step_scan();
        end
        o.base      = base_f[BASE_W-1:0];
        o.next      = xfer_done ? '0 : scan_at[FRAME_W-1:0];
        o.next_retx = !xfer_done && retx_pass;
        o.done      = xfer_done;
        return o;
    endfunction

    task automatic report(input string what, input int got, input int exp_val);
        if (mismatches < 40)
            $display("%0t mismatch on %s: got %0d, wanted %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic push_query(input logic rs, input logic fd, input logic ad);
        query_t q;
        q.restart  = rs;
        q.frame_ok = fd;
        q.ack_ok   = ad;
        query_q.push_back(q);
        queries_sent++;
    endtask

    task automatic wait_drained();
        while (queries_taken != queries_sent || outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                apply_cfg(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(predict_outcome('{restart, frame_delivered, ack_delivered}));
                queries_taken++;
                req_taken    = 1;
                quiet_cycles = 0;
            end
        end
    end

    // advance or hold the request
    always @(negedge clk)
    begin
        if (!in_valid || req_taken)
        begin
            req_taken = 0;
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (query_q.size() != 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 14) - 1;
                in_valid <= 1'b0;
            end
            else if (query_q.size() != 0)
            begin
                next_query = query_q.pop_front();
                in_valid        <= 1'b1;
                restart         <= next_query.restart;
                frame_delivered <= next_query.frame_ok;
                ack_delivered   <= next_query.ack_ok;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            quiet_cycles = 0;
            if (outcome_q.size() == 0)
            begin
                report("unexpected result", 1, 0);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (frame_index !== want.frame)
                    report("frame_index", int'(frame_index), int'(want.frame));
                if (was_retransmission !== want.retx)
                    report("was_retransmission", int'(was_retransmission), int'(want.retx));
                if (ack_recorded !== want.acked)
                    report("ack_recorded", int'(ack_recorded), int'(want.acked));
                if (window_base !== want.base)
                    report("window_base", int'(window_base), int'(want.base));
                if (next_frame !== want.next)
                    report("next_frame", int'(next_frame), int'(want.next));
                if (next_is_retransmission !== want.next_retx)
                    report("next_is_retransmission", int'(next_is_retransmission),
                           int'(want.next_retx));
                if (all_done !== want.done)
                    report("all_done", int'(all_done), int'(want.done));
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          counted;
        int          phase;
        int          budget;
        int          hits;
        int unsigned total;
        bit          over;
        logic        fd;
        logic        ad;
        logic [CFG_W-1:0] fc;
        logic [CFG_W-1:0] ws;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = srs_seq_pkg::CFG_FRAME_COUNT;
        cfg_data        = '0;
        in_valid        = 1'b0;
        restart         = 1'b0;
        frame_delivered = 1'b0;
        ack_delivered   = 1'b0;
        out_stall       = 1'b0;
        count_reg       = 1;
        width_reg       = 1;
        begin_transfer();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single frame: every outcome, ignore after done, restart
        push_query(0, 0, 0);
        push_query(0, 1, 0);
        push_query(0, 0, 1);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        push_query(0, 0, 0);
        push_query(1, 0, 0);
        push_query(0, 1, 1);
        push_query(1, 1, 1);
        wait_drained();

        // zero count and zero window
        write_reg(srs_seq_pkg::CFG_FRAME_COUNT, 0);
        write_reg(srs_seq_pkg::CFG_WINDOW_SIZE, 0);
        push_query(0, 1, 1);
        push_query(1, 0, 1);
        wait_drained();

        // window wider than the transfer
        write_reg(srs_seq_pkg::CFG_FRAME_COUNT, 4);
        write_reg(srs_seq_pkg::CFG_WINDOW_SIZE, 127);
        push_query(0, 1, 1);
        push_query(0, 0, 0);
        push_query(0, 1, 1);
        push_query(0, 1, 0);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        push_query(0, 1, 0);
        wait_drained();

        // two-frame window sliding over five frames
        write_reg(srs_seq_pkg::CFG_FRAME_COUNT, 5);
        write_reg(srs_seq_pkg::CFG_WINDOW_SIZE, 2);
        push_query(0, 0, 0);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        push_query(0, 1, 1);
        wait_drained();

        counted = 0;
        phase   = 0;
        while (counted < ITEMS)
        begin
            wait_drained();
            case (phase)
                0:       begin fc = 127; ws = 127; end
                1:       begin fc = 64;  ws = 1;   end
                2:       begin fc = 0;   ws = 0;   end
                3:       begin fc = 2;   ws = 127; end
                4:       begin fc = 1;   ws = 0;   end
                default:
                begin
                    fc = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 12));
                    ws = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 5));
                end
            endcase
            write_reg(srs_seq_pkg::CFG_FRAME_COUNT, fc);
            if (phase < 5 || $urandom_range(0, 1) == 1)
                write_reg(srs_seq_pkg::CFG_WINDOW_SIZE, ws);
            idle_on = (counted < ITEMS - 150) && ($urandom_range(0, 3) != 0);
            total   = clamp_count(fc);
            budget  = $urandom_range(20, 40) + (3 * total) / 2;
            hits    = 0;
            over    = 0;
            while (budget > 0)
            begin
                fd = $urandom_range(0, 9) < 8;
                ad = $urandom_range(0, 9) < 8;
                if (over)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_query(0, fd, ad);
                    end
                    else
                    begin
                        push_query(1, fd, ad);
                        over = 0;
                        hits = 0;
                        budget--;
                        counted++;
                    end
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    push_query(1, fd, ad);
                    hits = 0;
                    budget--;
                    counted++;
                end
                else
                begin
                    push_query(0, fd, ad);
                    if (fd && ad)
                    begin
                        hits++;
                        over = (hits == total);
                    end
                    budget--;
                    counted++;
                end
            end
            phase++;
        end

        wait_drained();
        idle_on = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            report("results still outstanding", 0, outcome_q.size());
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
